// ===== hw/rtl/elgamal_byte_cipher_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef ELGAMAL_BYTE_CIPHER_CORE_ASSERT_SVH
`define ELGAMAL_BYTE_CIPHER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ebc check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ebc check failed");

`endif

// ===== hw/rtl/ebc_pkg.sv =====
package ebc_pkg;

	// Modulus width and derived widths.
	localparam int W = 15;
	localparam int DW = 2 * W;
	localparam int BYTE_W = 8;
	localparam int CNT_W = $clog2(DW + 1);
	localparam int IDX_W = $clog2(W);
	localparam int REG_IDX_W = 2;

	typedef logic [W-1:0] word_t;
	typedef logic [DW-1:0] dword_t;

	// Operation codes.
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_PRIME = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GEN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PUB = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PRIV = 2'd3;

	localparam word_t ONE = word_t'(1);

	// State of one item inside the exponentiation chain.
	typedef struct packed {
		logic op;
		word_t msg;
		word_t base_a;
		word_t acc_a;
		word_t exp_a;
		word_t base_b;
		word_t acc_b;
		word_t exp_b;
	} item_t;

	// Key material and setup status.
	typedef struct packed {
		word_t p;
		word_t g;
		word_t d;
		word_t exdec;
		dword_t mu;
		logic busy;
	} key_t;

endpackage

// ===== hw/rtl/ebc_modmul.sv =====
// Four-stage Barrett modular multiplier: r = (a * b) mod p, for p >= 2.
module ebc_modmul (
	input logic clk,
	input logic en,
	input ebc_pkg::word_t a,
	input ebc_pkg::word_t b,
	input ebc_pkg::word_t p,
	input ebc_pkg::dword_t mu,
	output ebc_pkg::word_t r
);

	ebc_pkg::dword_t x_s1;
	ebc_pkg::dword_t x_s2;
	ebc_pkg::dword_t q_s2;
	logic [ebc_pkg::W:0] y_s3;
	ebc_pkg::word_t r_s4;
	logic [2*ebc_pkg::DW-1:0] t;
	logic [ebc_pkg::W:0] qp;

	// Quotient estimate from the reciprocal.
	assign t = {{ebc_pkg::DW{1'b0}}, x_s1} * {{ebc_pkg::DW{1'b0}}, mu};

	// The remainder stays below 2p, so only the low bits of q*p matter.
	assign qp = q_s2[ebc_pkg::W:0] * {1'b0, p};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= ebc_pkg::dword_t'(a) * ebc_pkg::dword_t'(b);
			x_s2 <= x_s1;
			q_s2 <= t[2*ebc_pkg::DW-1:ebc_pkg::DW];
			y_s3 <= x_s2[ebc_pkg::W:0] - qp;
			r_s4 <= (y_s3 >= {1'b0, p}) ? ebc_pkg::word_t'(y_s3 - {1'b0, p})
				: y_s3[ebc_pkg::W-1:0];
		end
	end

	assign r = r_s4;

endmodule

// ===== hw/rtl/ebc_step.sv =====
// One exponent bit for both exponentiation lanes: square the base and
// conditionally multiply the accumulator.
module ebc_step (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input ebc_pkg::item_t in_item,
	input ebc_pkg::word_t p,
	input ebc_pkg::dword_t mu,
	output logic out_valid,
	output ebc_pkg::item_t out_item
);

	ebc_pkg::word_t mul_a_op;
	ebc_pkg::word_t mul_b_op;
	ebc_pkg::word_t sq_a;
	ebc_pkg::word_t sq_b;
	ebc_pkg::word_t acc_a;
	ebc_pkg::word_t acc_b;
	ebc_pkg::item_t side_in;
	ebc_pkg::item_t side_s1;
	ebc_pkg::item_t side_s2;
	ebc_pkg::item_t side_s3;
	ebc_pkg::item_t side_s4;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;

	// A zero exponent bit multiplies by one.
	assign mul_a_op = in_item.exp_a[0] ? in_item.base_a : ebc_pkg::ONE;
	assign mul_b_op = in_item.exp_b[0] ? in_item.base_b : ebc_pkg::ONE;

	ebc_modmul u_sq_a (.clk(clk), .en(en), .a(in_item.base_a), .b(in_item.base_a),
		.p(p), .mu(mu), .r(sq_a));
	ebc_modmul u_mul_a (.clk(clk), .en(en), .a(in_item.acc_a), .b(mul_a_op),
		.p(p), .mu(mu), .r(acc_a));
	ebc_modmul u_sq_b (.clk(clk), .en(en), .a(in_item.base_b), .b(in_item.base_b),
		.p(p), .mu(mu), .r(sq_b));
	ebc_modmul u_mul_b (.clk(clk), .en(en), .a(in_item.acc_b), .b(mul_b_op),
		.p(p), .mu(mu), .r(acc_b));

	// Valid bits travel alongside the multipliers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Operation, message and the exponents, shifted to the next bit.
	always_comb begin
		side_in = in_item;
		side_in.exp_a = in_item.exp_a >> 1;
		side_in.exp_b = in_item.exp_b >> 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	always_comb begin
		out_item = side_s4;
		out_item.base_a = sq_a;
		out_item.acc_a = acc_a;
		out_item.base_b = sq_b;
		out_item.acc_b = acc_b;
	end

	assign out_valid = v_s4;

endmodule

// ===== hw/rtl/ebc_keysched.sv =====
// Configuration registers plus the setup sequencer that derives the
// Barrett reciprocal floor(2^DW / p) and the decrypt exponent.
module ebc_keysched (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ebc_pkg::REG_IDX_W-1:0] wr_index,
	input ebc_pkg::word_t wr_data,
	output ebc_pkg::key_t key
);

	ebc_pkg::word_t p_q;
	ebc_pkg::word_t g_q;
	ebc_pkg::word_t d_q;
	ebc_pkg::word_t c_q;
	ebc_pkg::word_t rem_mu_q;
	ebc_pkg::word_t rem_c_q;
	ebc_pkg::dword_t mu_q;
	ebc_pkg::word_t exdec_q;
	logic [ebc_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic fin_q;

	ebc_pkg::word_t pm1;
	ebc_pkg::word_t cred;
	logic [ebc_pkg::W:0] mu_sh;
	logic [ebc_pkg::W:0] c_sh;
	logic mu_ge;
	logic c_ge;
	logic c_step;
	logic c_bit;
	ebc_pkg::word_t mu_nrem;
	ebc_pkg::word_t c_nrem;

	assign pm1 = p_q - ebc_pkg::ONE;

	// Restoring division of 2^DW by p, one quotient bit per cycle.
	assign mu_sh = {rem_mu_q, (cnt_q == ebc_pkg::CNT_W'(ebc_pkg::DW))};
	assign mu_ge = (mu_sh >= {1'b0, p_q});
	assign mu_nrem = mu_ge ? ebc_pkg::word_t'(mu_sh - {1'b0, p_q})
		: mu_sh[ebc_pkg::W-1:0];

	// Remainder of the private key by p-1, taken from its top bit down while the count is below W.
	assign c_step = (cnt_q < ebc_pkg::CNT_W'(ebc_pkg::W));
	assign c_bit = c_step ? c_q[cnt_q[ebc_pkg::IDX_W-1:0]] : 1'b0;
	assign c_sh = {rem_c_q, c_bit};
	assign c_ge = (c_sh >= {1'b0, pm1});
	assign c_nrem = c_ge ? ebc_pkg::word_t'(c_sh - {1'b0, pm1})
		: c_sh[ebc_pkg::W-1:0];

	assign cred = (c_q > pm1) ? rem_c_q : c_q;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= ebc_pkg::word_t'(257);
			g_q <= ebc_pkg::word_t'(2);
			d_q <= ebc_pkg::word_t'(1);
			c_q <= ebc_pkg::word_t'(1);
		end else if (wr_en) begin
			case (wr_index)
				ebc_pkg::REG_PRIME: p_q <= wr_data;
				ebc_pkg::REG_GEN: g_q <= wr_data;
				ebc_pkg::REG_PUB: d_q <= wr_data;
				ebc_pkg::REG_PRIV: c_q <= wr_data;
				default: p_q <= p_q;
			endcase
		end
	end

	// Setup sequencer; any write restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			fin_q <= 1'b0;
			cnt_q <= ebc_pkg::CNT_W'(ebc_pkg::DW);
			rem_mu_q <= '0;
			rem_c_q <= '0;
			mu_q <= '0;
		end else if (wr_en) begin
			busy_q <= 1'b1;
			fin_q <= 1'b0;
			cnt_q <= ebc_pkg::CNT_W'(ebc_pkg::DW);
			rem_mu_q <= '0;
			rem_c_q <= '0;
		end else begin
			fin_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				rem_mu_q <= mu_nrem;
				mu_q <= {mu_q[ebc_pkg::DW-2:0], mu_ge};
				if (c_step) begin
					rem_c_q <= c_nrem;
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - ebc_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		exdec_q <= pm1 - cred;
	end

	always_comb begin
		key.p = p_q;
		key.g = g_q;
		key.d = d_q;
		key.exdec = exdec_q;
		key.mu = mu_q;
		key.busy = busy_q | fin_q;
	end

endmodule

// ===== hw/rtl/elgamal_byte_cipher_core.sv =====
// Channel   Direction  Handshake            Payload
// config    in         wr_en                wr_index, wr_data
// item      in         in_valid / in_stall  operation, plain_byte, nonce, cipher_value,
//                                           ephemeral_in
// result    out        out_valid / out_stall main_value, ephemeral_out
//
// One item per cycle while in_stall is low; an item passes through an input
// register, W exponent-bit steps of four-stage Barrett multipliers, a final
// four-stage multiply and the output register.
// After reset and after any configuration write, in_stall stays high while
// the setup divider derives the modulus reciprocal and the decrypt exponent.
// out_stall freezes the pipeline only when a valid result waits behind a full output.
module elgamal_byte_cipher_core (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ebc_pkg::REG_IDX_W-1:0] wr_index,
	input ebc_pkg::word_t wr_data,
	input logic in_valid,
	output logic in_stall,
	input logic operation,
	input logic [ebc_pkg::BYTE_W-1:0] plain_byte,
	input ebc_pkg::word_t nonce,
	input ebc_pkg::word_t cipher_value,
	input ebc_pkg::word_t ephemeral_in,
	output logic out_valid,
	input logic out_stall,
	output ebc_pkg::word_t main_value,
	output ebc_pkg::word_t ephemeral_out
);

	ebc_pkg::key_t key;
	logic en;
	ebc_pkg::item_t item_s0;
	logic v_s0;
	ebc_pkg::item_t chain_item [ebc_pkg::W+1];
	logic chain_v [ebc_pkg::W+1];
	ebc_pkg::item_t last;
	ebc_pkg::word_t fin_b;
	ebc_pkg::word_t fin_r;
	ebc_pkg::item_t fside_s1;
	ebc_pkg::item_t fside_s2;
	ebc_pkg::item_t fside_s3;
	ebc_pkg::item_t fside_s4;
	logic fv_s1;
	logic fv_s2;
	logic fv_s3;
	logic fv_s4;
	logic out_valid_q;
	ebc_pkg::word_t main_q;
	ebc_pkg::word_t eph_q;
	logic p_small;

	ebc_keysched u_keys (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .key(key)
	);

	// The pipeline halts only when a valid result meets a held output.
	assign en = !(out_valid_q && out_stall && fv_s4);
	assign in_stall = key.busy || !en;

	// Input register: choose bases and exponents for the operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid && !key.busy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s0.op <= operation;
			item_s0.acc_a <= ebc_pkg::ONE;
			item_s0.acc_b <= ebc_pkg::ONE;
			item_s0.base_b <= key.d;
			item_s0.exp_b <= nonce;
			if (operation == ebc_pkg::OP_DECRYPT) begin
				item_s0.msg <= cipher_value;
				item_s0.base_a <= ephemeral_in;
				item_s0.exp_a <= key.exdec;
			end else begin
				item_s0.msg <= {{(ebc_pkg::W-ebc_pkg::BYTE_W){1'b0}}, plain_byte};
				item_s0.base_a <= key.g;
				item_s0.exp_a <= nonce;
			end
		end
	end

	assign chain_item[0] = item_s0;
	assign chain_v[0] = v_s0;

	// Exponentiation chain, least significant exponent bit first.
	for (genvar i = 0; i < ebc_pkg::W; i++) begin : g_step
		ebc_step u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(chain_v[i]), .in_item(chain_item[i]),
			.p(key.p), .mu(key.mu),
			.out_valid(chain_v[i+1]), .out_item(chain_item[i+1])
		);
	end

	// Final multiply: message by the matching power.
	assign last = chain_item[ebc_pkg::W];
	assign fin_b = (last.op == ebc_pkg::OP_DECRYPT) ? last.acc_a : last.acc_b;

	ebc_modmul u_fin (.clk(clk), .en(en), .a(last.msg), .b(fin_b),
		.p(key.p), .mu(key.mu), .r(fin_r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s1 <= 1'b0;
			fv_s2 <= 1'b0;
			fv_s3 <= 1'b0;
			fv_s4 <= 1'b0;
		end else if (en) begin
			fv_s1 <= chain_v[ebc_pkg::W];
			fv_s2 <= fv_s1;
			fv_s3 <= fv_s2;
			fv_s4 <= fv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fside_s1 <= last;
			fside_s2 <= fside_s1;
			fside_s3 <= fside_s2;
			fside_s4 <= fside_s3;
		end
	end

	// A modulus of zero or one yields zero results.
	assign p_small = (key.p[ebc_pkg::W-1:1] == '0);

	// Output register; it refills whenever it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!(out_valid_q && out_stall)) begin
			out_valid_q <= fv_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (!(out_valid_q && out_stall)) begin
			if (p_small) begin
				main_q <= '0;
				eph_q <= '0;
			end else if (fside_s4.op == ebc_pkg::OP_DECRYPT) begin
				main_q <= {{(ebc_pkg::W-ebc_pkg::BYTE_W){1'b0}},
					fin_r[ebc_pkg::BYTE_W-1:0]};
				eph_q <= '0;
			end else begin
				main_q <= fin_r;
				eph_q <= fside_s4.acc_a;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign main_value = main_q;
	assign ephemeral_out = eph_q;

endmodule

// ===== hw/rtl/ebc_checker.sv =====
`include "elgamal_byte_cipher_core_assert.svh"

// Port-level checks on the cipher core.
module ebc_checker (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input ebc_pkg::word_t main_value,
	input ebc_pkg::word_t ephemeral_out
);

	// A held result transaction stays offered.
	`EBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// A held result transaction keeps its payload.
	`EBC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(main_value) && $stable(ephemeral_out))

	// A configuration write starts key setup, which blocks new items.
	`EBC_ASSERT_NEXT(a_cfg_stall, wr_en, in_stall ##1 in_stall)

	// Results are reduced below the modulus, which is at most all ones.
	`EBC_ASSERT_NOW(a_main_range, out_valid, (&main_value) == 1'b0)

endmodule

bind elgamal_byte_cipher_core ebc_checker u_ebc_checker (.*);
